@@ sv/pff_pkg.sv @@
// shared types and constants of the potential field force block
package pff_pkg;

  localparam int unsigned NUM_OBSTACLES_DEF = 2;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned FORCE_W = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned REP_W   = 41;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [REP_W-1:0] REP_CAP = REP_W'(64'h100_0000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_X   = 3'd0,
    CFG_GOAL_Y   = 3'd1,
    CFG_ATTR_GN  = 3'd2,
    CFG_REP_GN   = 3'd3,
    CFG_RADIUS   = 3'd4
  } cfg_idx_e;

  localparam logic ACT_FORCE = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

endpackage

@@ sv/pff_cell.sv @@
// one obstacle slot of the rotating obstacle chain
module pff_cell (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        shift_i,
  input  logic [pff_pkg::ENTRY_W-1:0] load_data_i,
  input  logic [pff_pkg::ENTRY_W-1:0] shift_data_i,
  output logic [pff_pkg::ENTRY_W-1:0] entry_o
);
  import pff_pkg::*;

  logic [ENTRY_W-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= load_data_i;
    end else if (shift_i) begin
      entry_q <= shift_data_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ sv/pff_isqrt.sv @@
// bit-serial integer square root, two bits of input per cycle
module pff_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] val_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  import pff_pkg::*;

  logic [31:0] v_q, res_q, bit_q, trial;
  logic        done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (bit_q == 32'd1);
      if (start_i) begin
        bit_q <= 32'h4000_0000;
      end else if (bit_q != '0) begin
        bit_q <= bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[15:0];

endmodule

@@ sv/pff_div.sv @@
// restoring 64 by 64 bit divider, one quotient bit per cycle
module pff_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  import pff_pkg::*;

  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[63]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ sv/potential_field_force.sv @@
// potential field force top level: obstacle cell chain and shared force sequencer
//
//   channel   dir  content
//   s_axis    in   tuser action, tdata obstacle_index/pos_x/pos_y
//   m_axis    out  tuser saturated, tdata force_x/force_y
//   cfg       in   write enable, register index, 16 bit data
//
// an obstacle load is taken while idle and gives no result; a force item runs the
// attractive term and then, per obstacle, the distance check and, inside the radius,
// the 16 step square root and the 64 step serial dividers
// reset is asynchronous and active low; the obstacle slots are not cleared
// a finished result waits in the output register while the next beat is taken;
// the following result holds until that one drains
module potential_field_force #(
  parameter int unsigned NUM_OBSTACLES = pff_pkg::NUM_OBSTACLES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pff_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // obstacle_index, pos_x, pos_y
  input  logic                           s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pff_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // force_x, force_y
  output logic                           m_axis_tuser,  // saturated
  input  logic                           cfg_we_i,
  input  logic [pff_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import pff_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_OBSTACLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ATTR, S_DIFF, S_SQ, S_SUM, S_CHK, S_SQRT, S_D1, S_D2, S_D3,
    S_DIV, S_ACC, S_NEXT, S_CLIP, S_DONE
  } state_e;

  state_e state_q;

  logic [15:0] goal_x_q, goal_y_q, attr_gain_q, rep_gain_q, radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      attr_gain_q <= 16'd384;
      rep_gain_q  <= 16'd384;
      radius_q    <= 16'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GOAL_X:  goal_x_q    <= cfg_data_i;
        CFG_GOAL_Y:  goal_y_q    <= cfg_data_i;
        CFG_ATTR_GN: attr_gain_q <= cfg_data_i;
        CFG_REP_GN:  rep_gain_q  <= cfg_data_i;
        CFG_RADIUS:  radius_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic       s_fire, load_fire, force_fire, in_idx;
  logic [15:0] in_x, in_y;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign in_idx     = s_axis_tdata[0];
  assign in_x       = s_axis_tdata[16:1];
  assign in_y       = s_axis_tdata[32:17];
  assign load_fire  = s_fire && (s_axis_tuser == ACT_LOAD);
  assign force_fire = s_fire && (s_axis_tuser == ACT_FORCE);

  // obstacle chain rotates toward cell 0
  logic [ENTRY_W-1:0] entry [NUM_OBSTACLES];
  logic               rotate;

  assign rotate = (state_q == S_NEXT);

  for (genvar i = 0; i < NUM_OBSTACLES; i++) begin : g_cell
    pff_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (load_fire && (32'(in_idx) == i)),
      .shift_i      (rotate),
      .load_data_i  ({in_x, in_y}),
      .shift_data_i (entry[(i + 1) % NUM_OBSTACLES]),
      .entry_o      (entry[i])
    );
  end

  logic [15:0] px_q, py_q;
  logic [CntW-1:0] cnt_q;
  logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
  logic sat_q;
  logic [31:0] rr_q;
  logic signed [16:0] dx_q, dy_q;
  logic [32:0] sqx_q, sqy_q;
  logic [33:0] d2_q;
  logic [15:0] d_q;
  logic [31:0] dd_q, cm_q;
  logic [47:0] ddd_q, nx_q, ny_q;
  logic [63:0] den_q;
  logic        div_start_q, sqrt_start_q;

  // attractive term
  logic signed [16:0] gdx, gdy;
  logic [16:0] gax, gay;
  logic [32:0] apx, apy;
  logic signed [ACC_W-1:0] attr_x, attr_y;

  assign gdx = $signed({goal_x_q[15], goal_x_q}) - $signed({px_q[15], px_q});
  assign gdy = $signed({goal_y_q[15], goal_y_q}) - $signed({py_q[15], py_q});
  assign gax = gdx[16] ? 17'(-gdx) : 17'(gdx);
  assign gay = gdy[16] ? 17'(-gdy) : 17'(gdy);
  assign apx = 33'(attr_gain_q) * 33'(gax);
  assign apy = 33'(attr_gain_q) * 33'(gay);
  assign attr_x = gdx[16] ? -$signed({23'd0, apx[32:8]}) : $signed({23'd0, apx[32:8]});
  assign attr_y = gdy[16] ? -$signed({23'd0, apy[32:8]}) : $signed({23'd0, apy[32:8]});

  // obstacle term
  logic [15:0] ox, oy;
  logic signed [33:0] sqx_full, sqy_full;
  logic [16:0] adx, ady;
  logic [48:0] nx_full, ny_full;

  assign ox = entry[0][31:16];
  assign oy = entry[0][15:0];
  assign sqx_full = 34'(dx_q) * 34'(dx_q);
  assign sqy_full = 34'(dy_q) * 34'(dy_q);
  assign adx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
  assign ady = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
  assign nx_full = 49'(cm_q) * 49'(adx);
  assign ny_full = 49'(cm_q) * 49'(ady);

  logic        sqrt_done, div_done_x, div_done_y;
  logic [15:0] root;
  logic [63:0] qx, qy;

  pff_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .val_i   (d2_q[31:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  pff_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   ({nx_q, 16'd0}),
    .den_i   (den_q),
    .done_o  (div_done_x),
    .quo_o   (qx)
  );

  pff_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   ({ny_q, 16'd0}),
    .den_i   (den_q),
    .done_o  (div_done_y),
    .quo_o   (qy)
  );

  logic [REP_W-1:0] rqx, rqy;
  logic             cap_x, cap_y;
  logic signed [ACC_W-1:0] rep_x, rep_y;

  assign cap_x = (qx > 64'(REP_CAP));
  assign cap_y = (qy > 64'(REP_CAP));
  assign rqx   = cap_x ? REP_CAP : qx[REP_W-1:0];
  assign rqy   = cap_y ? REP_CAP : qy[REP_W-1:0];
  assign rep_x = dx_q[16] ? -$signed({7'd0, rqx}) : $signed({7'd0, rqx});
  assign rep_y = dy_q[16] ? -$signed({7'd0, rqy}) : $signed({7'd0, rqy});

  localparam logic signed [ACC_W-1:0] FMAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] FMIN = -ACC_W'(64'sh8000_0000);

  logic [FORCE_W-1:0] fx_q, fy_q;
  logic               m_valid_q, m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      sat_q        <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      div_start_q  <= (state_q == S_D3);
      sqrt_start_q <= (state_q == S_CHK) && (d2_q != '0) && (d2_q < {2'b00, rr_q});
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (force_fire) begin
            state_q <= S_ATTR;
          end
        end
        S_ATTR: begin
          sat_q   <= 1'b0;
          cnt_q   <= '0;
          state_q <= S_DIFF;
        end
        S_DIFF: state_q <= S_SQ;
        S_SQ:   state_q <= S_SUM;
        S_SUM:  state_q <= S_CHK;
        S_CHK: begin
          if (d2_q == '0) begin
            sat_q   <= 1'b1;
            state_q <= S_NEXT;
          end else if (d2_q < {2'b00, rr_q}) begin
            state_q <= S_SQRT;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state_q <= S_D1;
          end
        end
        S_D1: state_q <= S_D2;
        S_D2: state_q <= S_D3;
        S_D3: state_q <= S_DIV;
        S_DIV: begin
          if (div_done_x) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (cap_x || cap_y) begin
            sat_q <= 1'b1;
          end
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (cnt_q == CntW'(NUM_OBSTACLES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_CLIP;
          end else begin
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_DIFF;
          end
        end
        S_CLIP: begin
          if (acc_x_q > FMAX || acc_x_q < FMIN || acc_y_q > FMAX || acc_y_q < FMIN) begin
            sat_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (force_fire) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    case (state_q)
      S_ATTR: begin
        acc_x_q <= attr_x;
        acc_y_q <= attr_y;
        rr_q    <= 32'(radius_q) * 32'(radius_q);
      end
      S_DIFF: begin
        dx_q <= $signed({px_q[15], px_q}) - $signed({ox[15], ox});
        dy_q <= $signed({py_q[15], py_q}) - $signed({oy[15], oy});
      end
      S_SQ: begin
        sqx_q <= sqx_full[32:0];
        sqy_q <= sqy_full[32:0];
      end
      S_SUM: d2_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
      S_SQRT: d_q <= root;
      S_D1: begin
        dd_q <= 32'(d_q) * 32'(d_q);
        cm_q <= 32'(rep_gain_q) * 32'(radius_q - d_q);
      end
      S_D2: begin
        ddd_q <= 48'(dd_q) * 48'(d_q);
        nx_q  <= nx_full[47:0];
        ny_q  <= ny_full[47:0];
      end
      S_D3: den_q <= 64'(ddd_q) * 64'(radius_q);
      S_ACC: begin
        acc_x_q <= acc_x_q + rep_x;
        acc_y_q <= acc_y_q + rep_y;
      end
      S_CLIP: begin
        fx_q <= (acc_x_q > FMAX) ? FMAX[FORCE_W-1:0] :
                (acc_x_q < FMIN) ? FMIN[FORCE_W-1:0] : acc_x_q[FORCE_W-1:0];
        fy_q <= (acc_y_q > FMAX) ? FMAX[FORCE_W-1:0] :
                (acc_y_q < FMIN) ? FMIN[FORCE_W-1:0] : acc_y_q[FORCE_W-1:0];
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {fy_q, fx_q};
          m_user_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat without finished computation");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !$rose(m_valid_q))
    else $error("obstacle load produced a result");

  a_chain_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q == '0))
    else $error("obstacle chain not back in order when idle");

  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_x == div_done_y)
    else $error("dividers out of step");

endmodule

@@ tb/sv/tb_potential_field_force.sv @@
// testbench of the potential field force block: directed and random beats against a predictor
module tb_potential_field_force;
  timeunit 1ns;
  timeprecision 1ps;
  import pff_pkg::*;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               sat;
  } force_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  potential_field_force dut (.*);

  // predictor state
  logic signed [15:0] goal_x_q, goal_y_q;
  logic [15:0] attr_gain_q, rep_gain_q, radius_q;
  logic signed [15:0] obs_x_q [2];
  logic signed [15:0] obs_y_q [2];

  force_t expected_forces [$];
  int mismatches, forces_seen, sat_seen, loads_sent;
  bit quiet_send, quiet_recv;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL potential_field_force");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint repulse(int delta, longint unsigned common,
                                     longint unsigned den, ref bit sat);
    longint unsigned mag, q;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    q = (common * mag) / den;
    if (q > (64'd1 << 40)) begin
      q = 64'd1 << 40;
      sat = 1'b1;
    end
    return (delta < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint attract(int delta);
    longint unsigned mag;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    mag = (longint'(attr_gain_q) * mag) >> 8;
    return (delta < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] clip_force(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic force_t predict_force(logic signed [15:0] px, logic signed [15:0] py);
    force_t res;
    longint fx, fy;
    longint unsigned r, d2, d, common, den;
    int dx, dy;
    bit sat;
    sat = 1'b0;
    r = radius_q;
    fx = attract(int'(goal_x_q) - int'(px));
    fy = attract(int'(goal_y_q) - int'(py));
    for (int i = 0; i < 2; i++) begin
      dx = int'(px) - int'(obs_x_q[i]);
      dy = int'(py) - int'(obs_y_q[i]);
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      if (d2 == 0) begin
        sat = 1'b1;
        continue;
      end
      if (d2 >= r * r) continue;
      d = int_sqrt(d2);
      common = longint'(rep_gain_q) * (r - d) * 65536;
      den = d * d * d * r;
      fx += repulse(dx, common, den, sat);
      fy += repulse(dy, common, den, sat);
    end
    res.fx = clip_force(fx, sat);
    res.fy = clip_force(fy, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic send_beat(logic act, logic idx, logic [15:0] px, logic [15:0] py);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 16);
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = {7'b0, py, px, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_LOAD) begin
      obs_x_q[idx] = px;
      obs_y_q[idx] = py;
      loads_sent++;
    end else begin
      expected_forces.push_back(predict_force(px, py));
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_GOAL_X:  goal_x_q = val;
      CFG_GOAL_Y:  goal_y_q = val;
      CFG_ATTR_GN: attr_gain_q = val;
      CFG_REP_GN:  rep_gain_q = val;
      CFG_RADIUS:  radius_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all(logic [15:0] gx, logic [15:0] gy, logic [15:0] ag,
                         logic [15:0] rg, logic [15:0] rad);
    wait_idle();
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    write_reg(CFG_ATTR_GN, ag);
    write_reg(CFG_REP_GN, rg);
    write_reg(CFG_RADIUS, rad);
  endtask

  // reset defaults with both slots loaded first
  task automatic test_defaults();
    send_beat(ACT_LOAD, 1'b0, 16'h0100, 16'h0100);
    send_beat(ACT_LOAD, 1'b1, 16'h8000, 16'h7fff);
    send_beat(ACT_FORCE, 1'b0, 16'h0000, 16'h0000);
    send_beat(ACT_FORCE, 1'b1, 16'h0100, 16'h0100);
    send_beat(ACT_FORCE, 1'b0, 16'h0101, 16'h0100);
    send_beat(ACT_FORCE, 1'b0, 16'h0180, 16'h00c0);
    send_beat(ACT_FORCE, 1'b0, 16'h8000, 16'h7fff);
    send_beat(ACT_FORCE, 1'b0, 16'h7fff, 16'h8000);
    send_beat(ACT_FORCE, 1'b0, 16'h8001, 16'h7ffe);
  endtask

  // extreme gains, radius and goals; summed repulsion overflows the output
  task automatic test_extremes();
    set_all(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff);
    send_beat(ACT_LOAD, 1'b0, 16'h0000, 16'h0000);
    send_beat(ACT_LOAD, 1'b1, 16'h0002, 16'h0000);
    send_beat(ACT_FORCE, 1'b0, 16'h0001, 16'h0000);
    send_beat(ACT_FORCE, 1'b0, 16'h8000, 16'h7fff);
    send_beat(ACT_FORCE, 1'b0, 16'h0000, 16'h0001);
    send_beat(ACT_FORCE, 1'b0, 16'h0002, 16'h0000);
    set_all(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0001);
    send_beat(ACT_FORCE, 1'b0, 16'h7fff, 16'h8000);
    send_beat(ACT_FORCE, 1'b0, 16'h0001, 16'h0000);
    send_beat(ACT_FORCE, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    logic [15:0] rad, px, py, ox, oy;
    int sel;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: rad = 16'($urandom_range(1, 2048));
        1: rad = 16'hffff;
        2: rad = 16'h0001;
        default: rad = 16'($urandom);
      endcase
      set_all(16'($urandom), 16'($urandom), (ph == 5) ? 16'hffff : 16'($urandom),
              (ph == 6) ? 16'h0000 : 16'($urandom), rad);
      for (int i = 0; i < 2; i++)
        send_beat(ACT_LOAD, i[0], 16'($urandom), 16'($urandom));
      for (int n = 0; n < 170; n++) begin
        if (n % 40 == 0) begin
          quiet_send = ($urandom_range(0, 3) == 0);
          quiet_recv = ($urandom_range(0, 3) == 0);
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          send_beat(ACT_LOAD, 1'($urandom), 16'($urandom), 16'($urandom));
        end else if (sel == 1) begin
          send_beat(ACT_FORCE, 1'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          sel = $urandom_range(0, 1);
          ox = obs_x_q[sel];
          oy = obs_y_q[sel];
          if ($urandom_range(0, 19) == 0) begin
            px = ox;
            py = oy;
          end else begin
            px = ox + 16'($urandom_range(0, 2 * rad) - rad);
            py = oy + 16'($urandom_range(0, 2 * rad) - rad);
          end
          send_beat(ACT_FORCE, 1'($urandom), px, py);
        end
      end
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
  endtask

  // result side: random stalls, check at the rising edge
  initial begin
    force_t exp_f, act_f;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, 16);
      repeat (stall) @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      act_f = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
      forces_seen++;
      if (act_f.sat) sat_seen++;
      if (expected_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected force beat %p", act_f);
      end else begin
        exp_f = expected_forces.pop_front();
        if (act_f !== exp_f) begin
          mismatches++;
          if (mismatches <= 10)
            $display("force mismatch: exp fx=%0d fy=%0d sat=%0b got fx=%0d fy=%0d sat=%0b",
                     exp_f.fx, exp_f.fy, exp_f.sat, act_f.fx, act_f.fy, act_f.sat);
        end
      end
      @(negedge clk_i);
      m_axis_tready = 1'b0;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_GOAL_X;
    cfg_data_i = '0;
    goal_x_q = 0;
    goal_y_q = 0;
    attr_gain_q = 16'd384;
    rep_gain_q = 16'd384;
    radius_q = 16'd640;
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_extremes();
    test_random();
    wait_idle();
    $display("covered %0d force beats (%0d saturated) and %0d obstacle loads",
             forces_seen, sat_seen, loads_sent);
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("PASS potential_field_force");
    end else begin
      $display("FAIL potential_field_force");
    end
    $finish;
  end
endmodule
